@@ design/hbpd_pkg.sv @@
// ---------------------------------------------------------------------------
// hbpd_pkg
// Shared types, constants and helpers for the hierarchical peak decimator.
// ---------------------------------------------------------------------------
package hbpd_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int OFFSET_W       = 12;
    localparam int INDEX_W        = 20;
    localparam int LEVEL_W        = 2;
    localparam int MAG_W          = SAMPLE_W + 1;
    localparam int MAX_LEVELS     = 3;
    localparam int BLOCK_DEFAULT  = 16;
    localparam int LEVELS_DEFAULT = 3;
    localparam int RES_FIFO_DEPTH = 4;

    // input beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_data;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [LEVEL_W-1:0]         level;
        logic [INDEX_W-1:0]         block_index;
        logic [OFFSET_W-1:0]        peak_offset;
        logic signed [SAMPLE_W-1:0] peak_value;
        logic                       last_result;
    } out_beat_t;

    // candidate handed from one level to the next
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
        logic [OFFSET_W-1:0]        offset;
    } cand_t;

    // completed block reported by one level
    typedef struct packed {
        logic                       emit;
        logic [INDEX_W-1:0]         block_index;
        logic [OFFSET_W-1:0]        offset;
        logic signed [SAMPLE_W-1:0] value;
    } level_res_t;

    // magnitude of a sample, one bit wider so the most negative value fits
    function automatic logic [MAG_W-1:0] magnitude(logic signed [SAMPLE_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[SAMPLE_W-1], v};
        return ext[MAG_W-1] ? (~ext + MAG_W'(1)) : ext;
    endfunction

endpackage

@@ design/hbpd_level.sv @@
// ---------------------------------------------------------------------------
// hbpd_level
// One overview level: tracks the peak of the current block and reports it
// when the block fills or the stream ends.
// ---------------------------------------------------------------------------
module hbpd_level
    import hbpd_pkg::*;
#(
    parameter int BLOCK = BLOCK_DEFAULT,
    parameter int LEVEL = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cand_t      cand_in,
    input  logic       flush,
    output cand_t      cand_out,
    output level_res_t res
);

    localparam int CNT_W = (BLOCK > 2) ? $clog2(BLOCK) : 1;
    localparam int PROD_W = 2 * OFFSET_W;
    localparam logic [OFFSET_W-1:0] STRIDE = OFFSET_W'((BLOCK ** LEVEL) % (1 << OFFSET_W));
    localparam logic [CNT_W-1:0] LAST_FILL = CNT_W'(BLOCK - 1);

    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic signed [SAMPLE_W-1:0] best_val_reg, best_val_next;
    logic [OFFSET_W-1:0]        best_off_reg, best_off_next;
    logic [INDEX_W-1:0]         blk_reg, blk_next;

    logic [PROD_W-1:0]          off_prod;
    logic [OFFSET_W-1:0]        cand_off;
    logic                       take;
    logic signed [SAMPLE_W-1:0] new_val;
    logic [OFFSET_W-1:0]        new_off;
    logic                       emit;

    // candidate offset within this level's block, wraps at the offset width
    assign off_prod = PROD_W'(fill_reg) * PROD_W'(STRIDE);
    assign cand_off = off_prod[OFFSET_W-1:0] + cand_in.offset;

    // strictly larger magnitude replaces the held peak
    assign take    = cand_in.valid && (magnitude(cand_in.value) > magnitude(best_val_reg));
    assign new_val = take ? cand_in.value : best_val_reg;
    assign new_off = take ? cand_off : best_off_reg;
    assign emit    = cand_in.valid && ((fill_reg == LAST_FILL) || flush);

    // state update
    always_comb begin
        fill_next     = fill_reg;
        best_val_next = best_val_reg;
        best_off_next = best_off_reg;
        blk_next      = blk_reg;
        if (cand_in.valid) begin
            if (emit) begin
                fill_next     = '0;
                best_val_next = '0;
                best_off_next = '0;
                blk_next      = flush ? '0 : blk_reg + INDEX_W'(1);
            end else begin
                fill_next     = fill_reg + CNT_W'(1);
                best_val_next = new_val;
                best_off_next = new_off;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            best_val_reg <= '0;
            best_off_reg <= '0;
            blk_reg      <= '0;
        end else begin
            fill_reg     <= fill_next;
            best_val_reg <= best_val_next;
            best_off_reg <= best_off_next;
            blk_reg      <= blk_next;
        end
    end

    // outputs to the next level and to the result queue
    assign cand_out.valid  = emit;
    assign cand_out.value  = new_val;
    assign cand_out.offset = new_off;

    assign res.emit        = emit;
    assign res.block_index = blk_reg;
    assign res.offset      = new_off;
    assign res.value       = new_val;

endmodule

@@ design/hbpd_res_fifo.sv @@
// ---------------------------------------------------------------------------
// hbpd_res_fifo
// Small result queue: takes up to NPUSH results in a cycle (always a prefix
// of the push lanes) and hands out one beat per cycle while m_ready is high.
// ---------------------------------------------------------------------------
module hbpd_res_fifo
    import hbpd_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH,
    parameter int NPUSH = MAX_LEVELS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_en   [NPUSH],
    input  out_beat_t push_data [NPUSH],
    output logic      space_ok,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    out_beat_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   push_cnt;
    logic               pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign m_data   = mem_reg[rd_ptr_reg];
    assign space_ok = (count_reg <= CNT_W'(DEPTH - NPUSH));

    // number of results pushed this cycle
    always_comb begin
        push_cnt = '0;
        for (int k = 0; k < NPUSH; k++) begin
            push_cnt = push_cnt + CNT_W'(push_en[k]);
        end
    end

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_cnt - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, lane k lands k entries past the write pointer
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NPUSH; k++) begin
            if (push_en[k]) begin
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push_data[k];
            end
        end
    end

endmodule

@@ design/hierarchical_block_peak_decimator.sv @@
// ---------------------------------------------------------------------------
// hierarchical_block_peak_decimator
// Three-level peak overview of a signed Q1.15 sample stream.
// ---------------------------------------------------------------------------
// Takes one sample beat per cycle while s_ready is high. Each level keeps
// the largest-magnitude entry of its current block of BLOCK entries
// (earliest wins a tie) and reports it, with its block index and its offset
// in samples, when the block fills; a completed peak feeds the next level in
// the same cycle. A beat with end_of_data set flushes every level, finest
// first, and returns all state to reset. Results are registered in a 4-entry
// result queue and appear on m_ one per cycle while m_ready is high; s_ready
// drops only while that queue has fewer free entries than the number of
// levels. With the receiver always ready, a sample is taken every cycle,
// except that a beat that completes two blocks, or three (a flush), holds off
// the input while they drain.
// ---------------------------------------------------------------------------
module hierarchical_block_peak_decimator
    import hbpd_pkg::*;
#(
    parameter int BLOCK  = BLOCK_DEFAULT,
    parameter int LEVELS = LEVELS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int NLEV = (LEVELS < 1) ? 1 : ((LEVELS > MAX_LEVELS) ? MAX_LEVELS : LEVELS);

    logic       accept;
    cand_t      cand [NLEV+1];
    level_res_t res  [NLEV];
    logic       push_en   [NLEV];
    out_beat_t  push_data [NLEV];

    assign accept = s_valid && s_ready;

    // level 0 sees every accepted sample at offset zero
    assign cand[0].valid  = accept;
    assign cand[0].value  = s_data.sample;
    assign cand[0].offset = '0;

    // level chain
    for (genvar l = 0; l < NLEV; l++) begin : g_level
        hbpd_level #(
            .BLOCK (BLOCK),
            .LEVEL (l)
        ) u_level (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cand_in  (cand[l]),
            .flush    (s_data.end_of_data),
            .cand_out (cand[l+1]),
            .res      (res[l])
        );

        // result beat for this level, last flag on the highest level reporting
        assign push_en[l]               = res[l].emit;
        assign push_data[l].level       = LEVEL_W'(l);
        assign push_data[l].block_index = res[l].block_index;
        assign push_data[l].peak_offset = res[l].offset;
        assign push_data[l].peak_value  = res[l].value;
        if (l == NLEV - 1) begin : g_top
            assign push_data[l].last_result = res[l].emit;
        end else begin : g_mid
            assign push_data[l].last_result = res[l].emit && !res[l+1].emit;
        end
    end

    // unused spare candidate from the top level
    logic unused_top;
    assign unused_top = cand[NLEV].valid;

    // result queue
    hbpd_res_fifo #(
        .DEPTH (RES_FIFO_DEPTH),
        .NPUSH (NLEV)
    ) u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_data (push_data),
        .space_ok  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ dv/hierarchical_block_peak_decimator_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hierarchical_block_peak_decimator_test
// Self-checking bench for the three-level peak overview decimator.
// ---------------------------------------------------------------------------
// A short table of hand-picked samples is sent first. Rows that flush right
// after reset carry their peaks typed in. Every other row, and the random
// streams after it, are checked against a behavioral peak tracker kept in
// the bench. The random streams end in end_of_data. One longer stream closes
// several level-0 blocks, the last one together with its flush. Handshake
// pressure changes from phase to phase: a slow receiver with one long
// hold-off, then a slow sender, then neither.
// ---------------------------------------------------------------------------
module hierarchical_block_peak_decimator_test;
    import hbpd_pkg::*;

    localparam int BLOCK       = BLOCK_DEFAULT;
    localparam int LEVELS      = LEVELS_DEFAULT;
    localparam int NUM_LEVELS  = (LEVELS > MAX_LEVELS) ? MAX_LEVELS :
                                 ((LEVELS < 1) ? 1 : LEVELS);
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 3000;
    localparam int PHASE_BEATS = 36;
    localparam int MIN_PEAKS   = 48;
    localparam int LONG_STREAM = 48;
    localparam int DIR_ROWS    = 20;
    localparam int TYPED_BEATS = 9;

    // one row of the directed table: the beat and how many typed peaks follow
    typedef struct packed {
        in_beat_t   beat;
        logic [1:0] n_typed;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        {16'h8000, 1'b1, 2'd3},   // most negative sample flushed alone
        {16'h7FFF, 1'b1, 2'd3},   // most positive sample flushed alone
        {16'h0000, 1'b1, 2'd3},   // zero never replaces the starting peak
        {16'h0001, 1'b0, 2'd0},
        {16'hFED4, 1'b0, 2'd0},
        {16'h012C, 1'b0, 2'd0},   // same magnitude as the one before
        {16'h8001, 1'b0, 2'd0},
        {16'h7FFF, 1'b0, 2'd0},   // tie with -32767, earlier one stays
        {16'h0000, 1'b0, 2'd0},
        {16'hFFFF, 1'b0, 2'd0},
        {16'h8000, 1'b0, 2'd0},   // beats every other magnitude
        {16'h7FFF, 1'b0, 2'd0},
        {16'h8000, 1'b0, 2'd0},   // tie with the held -32768
        {16'h1234, 1'b0, 2'd0},
        {16'hEDCC, 1'b0, 2'd0},
        {16'h0002, 1'b0, 2'd0},
        {16'h0003, 1'b0, 2'd0},
        {16'h4000, 1'b0, 2'd0},
        {16'hC000, 1'b0, 2'd0},   // closes the first level-0 block
        {16'h0005, 1'b1, 2'd0}    // flush with a partial block at every level
    };

    localparam out_beat_t TYPED_PEAKS [TYPED_BEATS] = '{
        {2'd0, 20'd0, 12'd0, 16'h8000, 1'b0},
        {2'd1, 20'd0, 12'd0, 16'h8000, 1'b0},
        {2'd2, 20'd0, 12'd0, 16'h8000, 1'b1},
        {2'd0, 20'd0, 12'd0, 16'h7FFF, 1'b0},
        {2'd1, 20'd0, 12'd0, 16'h7FFF, 1'b0},
        {2'd2, 20'd0, 12'd0, 16'h7FFF, 1'b1},
        {2'd0, 20'd0, 12'd0, 16'h0000, 1'b0},
        {2'd1, 20'd0, 12'd0, 16'h0000, 1'b0},
        {2'd2, 20'd0, 12'd0, 16'h0000, 1'b1}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    hierarchical_block_peak_decimator #(
        .BLOCK  (BLOCK),
        .LEVELS (LEVELS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // peak tracker state, one entry per level
    int                         fill_count  [MAX_LEVELS];
    logic signed [SAMPLE_W-1:0] best_value  [MAX_LEVELS];
    logic [OFFSET_W-1:0]        best_offset [MAX_LEVELS];
    logic [INDEX_W-1:0]         block_count [MAX_LEVELS];

    out_beat_t expected_peaks [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_granted   = 0;
    int hold_left      = 0;
    int beats_sent     = 0;
    int peaks_expected = 0;
    int peaks_checked  = 0;
    int streams_done   = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int typed_next     = 0;
    int level_seen [MAX_LEVELS];

    function automatic int sample_mag(logic signed [SAMPLE_W-1:0] v);
        return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function automatic void clear_tracker();
        for (int lv = 0; lv < MAX_LEVELS; lv++) begin
            fill_count[lv]  = 0;
            best_value[lv]  = '0;
            best_offset[lv] = '0;
            block_count[lv] = '0;
        end
    endfunction

    // peaks that one sample beat completes, finest level first
    function automatic int track_peaks(input in_beat_t b,
                                       output out_beat_t res [MAX_LEVELS]);
        logic signed [SAMPLE_W-1:0] cand;
        logic [OFFSET_W-1:0]        cand_off;
        int                         stride;
        int                         n;
        cand     = b.sample;
        cand_off = '0;
        stride   = 1;
        n        = 0;
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            if (sample_mag(cand) > sample_mag(best_value[lv])) begin
                best_value[lv]  = cand;
                best_offset[lv] = OFFSET_W'(fill_count[lv] * stride + int'(cand_off));
            end
            fill_count[lv]++;
            if (fill_count[lv] < BLOCK && !b.end_of_data)
                break;
            res[n].level       = LEVEL_W'(lv);
            res[n].block_index = block_count[lv];
            res[n].peak_offset = best_offset[lv];
            res[n].peak_value  = best_value[lv];
            res[n].last_result = 1'b0;
            n++;
            // completed peak moves up as the next level's candidate
            cand            = best_value[lv];
            cand_off        = best_offset[lv];
            block_count[lv] = block_count[lv] + 1'b1;
            fill_count[lv]  = 0;
            best_value[lv]  = '0;
            best_offset[lv] = '0;
            stride          = stride * BLOCK;
        end
        if (b.end_of_data)
            clear_tracker();
        if (n > 0)
            res[n-1].last_result = 1'b1;
        return n;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one sample beat, then queue the peaks it completes
    task automatic send_sample(input in_beat_t b, input int n_typed);
        out_beat_t res [MAX_LEVELS];
        int        n;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
        if (b.end_of_data)
            streams_done++;
        n = track_peaks(b, res);
        if (n_typed > 0) begin
            for (int k = 0; k < n_typed; k++) begin
                expected_peaks.push_back(TYPED_PEAKS[typed_next]);
                typed_next++;
            end
            peaks_expected += n_typed;
        end else begin
            for (int k = 0; k < n; k++)
                expected_peaks.push_back(res[k]);
            peaks_expected += n;
        end
    endtask

    task automatic run_stream(input int len);
        in_beat_t b;
        for (int i = 0; i < len; i++) begin
            b.sample      = random_sample();
            b.end_of_data = (i == len - 1);
            send_sample(b, 0);
        end
    endtask

    // random streams until enough beats, and enough peaks where asked
    task automatic run_streams(input int beats, input int min_peaks);
        int start_beats;
        start_beats = beats_sent;
        while (beats_sent - start_beats < beats || peaks_expected < min_peaks) begin
            if ($urandom_range(0, 7) == 0)
                run_stream($urandom_range(40, 80));
            else
                run_stream($urandom_range(1, 36));
        end
    endtask

    // sender stays quiet until every queued peak is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_peaks.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // receiver ready, with random stalls and one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_granted != hold_asked) begin
            hold_granted <= hold_asked;
            hold_left    <= HOLD_CYCLES - 1;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each result beat with the oldest queued peak
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            peaks_checked++;
            if (expected_peaks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected peak beat: L%0d blk %0d off %0d val %0d last %0d",
                             m_data.level, m_data.block_index, m_data.peak_offset,
                             m_data.peak_value, m_data.last_result);
            end else begin
                want = expected_peaks.pop_front();
                if (m_data.level < MAX_LEVELS)
                    level_seen[m_data.level]++;
                if (m_data.level !== want.level
                        || m_data.block_index !== want.block_index
                        || m_data.peak_offset !== want.peak_offset
                        || m_data.peak_value !== want.peak_value
                        || m_data.last_result !== want.last_result) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"peak beat %0d: expected L%0d blk %0d off %0d val %0d",
                                  " last %0d, got L%0d blk %0d off %0d val %0d last %0d"},
                                 peaks_checked, want.level, want.block_index,
                                 want.peak_offset, want.peak_value, want.last_result,
                                 m_data.level, m_data.block_index, m_data.peak_offset,
                                 m_data.peak_value, m_data.last_result);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_tracker();
        for (int lv = 0; lv < MAX_LEVELS; lv++)
            level_seen[lv] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(DIR_TABLE[r].beat, int'(DIR_TABLE[r].n_typed));
        wait_drained();

        // slow receiver, with a long hold-off while samples keep coming
        send_idle_pct  = 10;
        recv_stall_pct = 80;
        hold_asked     = hold_asked + 1;
        run_streams(PHASE_BEATS, 0);
        wait_drained();

        // slow sender, eager receiver
        send_idle_pct  = 80;
        recv_stall_pct = 10;
        run_streams(PHASE_BEATS, 0);
        wait_drained();

        // full rate both ways, one stream that closes several level-0 blocks
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_stream(LONG_STREAM);
        run_streams(PHASE_BEATS, MIN_PEAKS);
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("%0d sample beats in %0d streams, %0d peak beats checked",
                 beats_sent, streams_done, peaks_checked);
        $display("peaks by level: %0d / %0d / %0d, %0d mismatches",
                 level_seen[0], level_seen[1], level_seen[2], mismatch_count);
        if (mismatch_count == 0 && expected_peaks.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
